@@ design/hss3d_pkg.sv @@
// shared types, constants and helpers for the 3d heat stencil sweep
package hss3d_pkg;

    // grid geometry
    localparam int MAX_DIM     = 64;
    localparam int PAD_DIM     = MAX_DIM + 2;
    localparam int PLANE_WORDS = PAD_DIM * PAD_DIM;
    localparam int STORE_WORDS = 2 * PLANE_WORDS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int POS_W       = 7;
    localparam int DATA_W      = 32;
    localparam int MAXC_W      = 31;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

    localparam logic [POS_W-1:0]  SIZE_RESET      = 7'd64;
    localparam logic [MAXC_W-1:0] THRESHOLD_RESET = 31'd10737;

    typedef struct packed {
        logic signed [DATA_W-1:0] grid_value;
        logic                     sweep_start;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_value;
        logic                     last_point;
        logic [MAXC_W-1:0]        max_change;
        logic                     converged;
    } out_word_t;

    typedef struct packed {
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
        logic [POS_W-1:0] sz;
    } sizes_t;

    // one interior point with all its stencil operands
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] behind;
        logic signed [DATA_W-1:0] old;
        logic signed [DATA_W-1:0] n_jm;
        logic signed [DATA_W-1:0] n_jp;
        logic signed [DATA_W-1:0] n_km;
        logic signed [DATA_W-1:0] n_kp;
        logic                     last;
        logic                     clr;
    } job_t;

    // size register clamped to 1..MAX_DIM
    function automatic logic [POS_W-1:0] eff_size(input logic [POS_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v == '0)
            r = POS_W'(1);
        else if (v > POS_W'(MAX_DIM))
            r = POS_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

@@ design/hss3d_front.sv @@
// front end: raster position, plane store and classification of interior points
module hss3d_front
    import hss3d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_word_t           in_word,
    input  sizes_t             sizes,
    input  logic [Q_CNT_W-1:0] q_count,
    output logic               push,
    output job_t               job
);

    logic                 acc;
    logic [POS_W-1:0]     sx, sy, sz;
    logic [POS_W-1:0]     p_reg, j_reg, k_reg;
    logic [POS_W-1:0]     p_next, j_next, k_next;
    logic [POS_W-1:0]     p_cur, j_cur, k_cur;
    logic [POS_W-1:0]     k_inc, j_inc, p_inc;
    logic                 interior, last;
    logic                 f1_valid_reg;
    logic                 clr_pend_reg, clr_pend_next;
    logic                 we;
    logic [ADDR_W-1:0]    off_c, base_p, base_s;
    logic [ADDR_W-1:0]    wr_addr, old_addr, km_addr, kp_addr, jm_addr, jp_addr;

    logic [DATA_W-1:0]    mem_a [STORE_WORDS];
    logic [DATA_W-1:0]    mem_b [STORE_WORDS];
    logic [DATA_W-1:0]    mem_c [STORE_WORDS];
    logic [DATA_W-1:0]    behind_q, old_q, km_q, kp_q, jm_q, jp_q;
    logic [DATA_W-1:0]    val_q;
    logic                 last_q, clr_q;

    // credit check: queue entries plus the word still in the read stage
    assign in_ready = ({1'b0, q_count} + {{Q_CNT_W{1'b0}}, f1_valid_reg})
                      < (Q_CNT_W+1)'(Q_DEPTH);
    assign acc = in_valid && in_ready;

    assign sx = eff_size(sizes.sx);
    assign sy = eff_size(sizes.sy);
    assign sz = eff_size(sizes.sz);

    // current position, sweep start forces the origin
    assign p_cur = in_word.sweep_start ? '0 : p_reg;
    assign j_cur = in_word.sweep_start ? '0 : j_reg;
    assign k_cur = in_word.sweep_start ? '0 : k_reg;

    // interior point (p-1, j, k) completes when (p, j, k) arrives
    assign interior = (p_cur >= POS_W'(2)) && ({1'b0, p_cur} <= {1'b0, sx} + 8'd1)
                   && (j_cur >= POS_W'(1)) && (j_cur <= sy)
                   && (k_cur >= POS_W'(1)) && (k_cur <= sz);
    assign last = ((p_cur - POS_W'(1)) == sx) && (j_cur == sy) && (k_cur == sz);

    // store addresses: slot by plane parity, fixed padded row pitch
    assign off_c    = ADDR_W'(j_cur) * ADDR_W'(PAD_DIM) + ADDR_W'(k_cur);
    assign base_p   = p_cur[0] ? ADDR_W'(PLANE_WORDS) : '0;
    assign base_s   = p_cur[0] ? '0 : ADDR_W'(PLANE_WORDS);
    assign wr_addr  = base_p + off_c;
    assign old_addr = base_s + off_c;
    assign km_addr  = old_addr - ADDR_W'(1);
    assign kp_addr  = old_addr + ADDR_W'(1);
    assign jm_addr  = old_addr - ADDR_W'(PAD_DIM);
    assign jp_addr  = old_addr + ADDR_W'(PAD_DIM);
    assign we = acc && (j_cur < POS_W'(PAD_DIM)) && (k_cur < POS_W'(PAD_DIM));

    // raster position advance
    assign k_inc = k_cur + POS_W'(1);
    assign j_inc = j_cur + POS_W'(1);
    assign p_inc = p_cur + POS_W'(1);
    always_comb
    begin
        p_next = p_cur;
        j_next = j_cur;
        k_next = k_inc;
        if (k_inc >= sz + POS_W'(2))
        begin
            k_next = '0;
            j_next = j_inc;
            if (j_inc >= sy + POS_W'(2))
            begin
                j_next = '0;
                p_next = (p_inc >= sx + POS_W'(2)) ? '0 : p_inc;
            end
        end
    end

    // pending clear rides on the next interior point
    assign clr_pend_next = interior ? 1'b0 : (clr_pend_reg || in_word.sweep_start);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            f1_valid_reg <= 1'b0;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= acc && interior;
            if (acc)
            begin
                p_reg        <= p_next;
                j_reg        <= j_next;
                k_reg        <= k_next;
                clr_pend_reg <= clr_pend_next;
            end
        end
    end

    // plane store, three copies for six reads a word
    always_ff @(posedge clk)
    begin
        if (we)
            mem_a[wr_addr] <= in_word.grid_value;
        if (acc)
        begin
            behind_q <= mem_a[wr_addr];
            old_q    <= mem_a[old_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem_b[wr_addr] <= in_word.grid_value;
        if (acc)
        begin
            km_q <= mem_b[km_addr];
            kp_q <= mem_b[kp_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem_c[wr_addr] <= in_word.grid_value;
        if (acc)
        begin
            jm_q <= mem_c[jm_addr];
            jp_q <= mem_c[jp_addr];
        end
    end

    // word fields alongside the read data
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            val_q  <= in_word.grid_value;
            last_q <= last;
            clr_q  <= clr_pend_reg || in_word.sweep_start;
        end
    end

    assign push       = f1_valid_reg;
    assign job.val    = val_q;
    assign job.behind = behind_q;
    assign job.old    = old_q;
    assign job.n_jm   = jm_q;
    assign job.n_jp   = jp_q;
    assign job.n_km   = km_q;
    assign job.n_kp   = kp_q;
    assign job.last   = last_q;
    assign job.clr    = clr_q;

endmodule

@@ design/hss3d_queue.sv @@
// short queue of stencil jobs between front and back
module hss3d_queue
    import hss3d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  job_t               job_in,
    input  logic               pop,
    output logic               valid,
    output job_t               job_out,
    output logic [Q_CNT_W-1:0] count
);

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign valid   = (count_reg != '0);
    assign job_out = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

    // pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + Q_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= job_in;
    end

    // credit scheme must never overfill the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != Q_CNT_W'(Q_DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");

endmodule

@@ design/hss3d_back.sv @@
// back end: stencil arithmetic, saturation, running maximum and output register
module hss3d_back
    import hss3d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  job_t              q_job,
    output logic              pop,
    input  logic [MAXC_W-1:0] threshold,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_word
);

    logic                     adv;
    logic                     b1_valid_reg, b2_valid_reg, out_valid_reg;
    logic signed [33:0]       sa, sb, sa_reg, sb_reg;
    logic signed [34:0]       six_old, six_old_reg;
    logic signed [DATA_W-1:0] old1_reg;
    logic                     last1_reg, last2_reg, clr1_reg, clr2_reg;
    logic signed [35:0]       diff;
    logic signed [DATA_W-1:0] delta, delta_reg;
    logic signed [32:0]       nv_wide;
    logic signed [DATA_W-1:0] nv_sat, nv_reg;
    logic [MAXC_W-1:0]        max_reg, max_cur, max_new;
    out_word_t                out_reg;

    // whole back pipeline moves together when the output can take a word
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && q_valid;

    // stage one: partial sums and six times the center
    assign sa = {{2{q_job.val[31]}}, q_job.val} + {{2{q_job.behind[31]}}, q_job.behind}
              + {{2{q_job.n_jm[31]}}, q_job.n_jm};
    assign sb = {{2{q_job.n_jp[31]}}, q_job.n_jp} + {{2{q_job.n_km[31]}}, q_job.n_km}
              + {{2{q_job.n_kp[31]}}, q_job.n_kp};
    assign six_old = ({{3{q_job.old[31]}}, q_job.old} <<< 2)
                   + ({{3{q_job.old[31]}}, q_job.old} <<< 1);

    // stage two: laplacian, floor divide by 16, saturating add
    assign diff    = {{2{sa_reg[33]}}, sa_reg} + {{2{sb_reg[33]}}, sb_reg}
                   - {six_old_reg[34], six_old_reg};
    assign delta   = diff[35:4];
    assign nv_wide = {old1_reg[31], old1_reg} + {delta[31], delta};
    always_comb
    begin
        if (nv_wide[32] != nv_wide[31])
            nv_sat = nv_wide[32] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            nv_sat = nv_wide[31:0];
    end

    // output stage: running maximum with floor zero
    assign max_cur = clr2_reg ? '0 : max_reg;
    assign max_new = (!delta_reg[31] && (delta_reg[30:0] > max_cur)) ? delta_reg[30:0]
                                                                      : max_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= q_valid;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
            if (b2_valid_reg)
                max_reg <= max_new;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg      <= sa;
            sb_reg      <= sb;
            six_old_reg <= six_old;
            old1_reg    <= q_job.old;
            last1_reg   <= q_job.last;
            clr1_reg    <= q_job.clr;
            delta_reg   <= delta;
            nv_reg      <= nv_sat;
            last2_reg   <= last1_reg;
            clr2_reg    <= clr1_reg;
            out_reg.new_value  <= nv_reg;
            out_reg.last_point <= last2_reg;
            out_reg.max_change <= max_new;
            out_reg.converged  <= last2_reg && (max_new < threshold);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // converged only ever accompanies the last point
    a_conv_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.converged |-> out_reg.last_point)
        else $error("converged without last point");

    // maximum never falls within a sweep
    a_max_mono: assert property (@(posedge clk) disable iff (!rst_n)
        adv && b2_valid_reg && !clr2_reg |=> max_reg >= $past(max_reg))
        else $error("running maximum decreased");

    // reported maximum matches the tracked maximum
    a_max_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && b2_valid_reg |=> out_reg.max_change == max_reg)
        else $error("reported maximum mismatch");

endmodule

@@ design/heat_stencil_3d_sweep_top.sv @@
// One Jacobi sweep of a 7-point 3D heat stencil on a padded grid streamed in raster order
// (outer axis slowest, inner fastest, halo included), signed Q2.30. Unless stalled, the block takes
// one grid word per clock and returns one updated interior point per clock, in raster order, each
// completed by its neighbor (i+1,j,k), then passed through the read registers, the job queue, two
// arithmetic stages and the output register. The rate is set by the plane store: two padded
// planes of 66x66 words kept in three copies so that the six operands of a point are read in the
// cycle its last neighbor is written. The result register and a four-word job queue let input
// and output stall independently. The user must write sizes and the convergence threshold through
// the plain config port only while the block idles (not enforced); size 0 acts as 1, above 64 as 64.
module heat_stencil_3d_sweep_top
    import hss3d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAXC_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_word_t             in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_word_t            out_word
);

    sizes_t             sizes_reg;
    logic [MAXC_W-1:0]  threshold_reg;
    logic               push, pop, q_valid;
    job_t               job_in, job_out;
    logic [Q_CNT_W-1:0] q_count;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sizes_reg.sx  <= SIZE_RESET;
            sizes_reg.sy  <= SIZE_RESET;
            sizes_reg.sz  <= SIZE_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIZE_X:    sizes_reg.sx  <= cfg_data[POS_W-1:0];
                REG_SIZE_Y:    sizes_reg.sy  <= cfg_data[POS_W-1:0];
                REG_SIZE_Z:    sizes_reg.sz  <= cfg_data[POS_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data;
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    hss3d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .sizes    (sizes_reg),
        .q_count  (q_count),
        .push     (push),
        .job      (job_in)
    );

    hss3d_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .valid   (q_valid),
        .job_out (job_out),
        .count   (q_count)
    );

    hss3d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (job_out),
        .pop       (pop),
        .threshold (threshold_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule
